[sv/ttps_pkg.sv]
// Shared types and codes for the transposition table probe/store block.
// Used by ttps_front, ttps_queue, ttps_back and the top level.
package ttps_pkg;

    // Input operation codes
    localparam logic [1:0] FUNC_PROBE = 2'd0;
    localparam logic [1:0] FUNC_STORE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Stored bound kinds
    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_UPPER = 2'd1;
    localparam logic [1:0] BOUND_LOWER = 2'd2;

    localparam logic [14:0] MATE_THRESHOLD_RESET = 15'd29000;

    typedef enum logic [1:0] {
        OP_PROBE,
        OP_STORE,
        OP_CLEAR,
        OP_NOP
    } op_t;

    // Classified request as it travels from front to back
    typedef struct packed {
        op_t                op;
        logic [63:0]        key;
        logic [7:0]         depth;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic [7:0]         ply;
        logic [1:0]         bound;
        logic signed [15:0] score;   // already mate-adjusted for a store
        logic [31:0]        move;
    } req_t;

    typedef struct packed {
        logic [63:0]        key;
        logic [7:0]         depth;
        logic [1:0]         bound;
        logic signed [15:0] score;
        logic [31:0]        move;
    } entry_t;

    typedef enum logic [1:0] {
        BK_INIT,
        BK_IDLE,
        BK_EXEC,
        BK_CLEAR
    } bk_state_t;

    typedef struct packed {
        logic init_busy;
    } bk_status_t;

endpackage

[sv/ttps_front.sv]
// Front end: request handshake, mate threshold register, classification
// and store score adjustment. Depends on ttps_pkg.
module ttps_front
    import ttps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [63:0]        pos_key,
    input  logic [7:0]         depth,
    input  logic signed [15:0] alpha,
    input  logic signed [15:0] beta,
    input  logic [7:0]         ply,
    input  logic [1:0]         bound_kind,
    input  logic signed [15:0] score,
    input  logic [31:0]        move_in,
    input  logic               cfg_wr_en,
    input  logic [14:0]        cfg_wr_data,
    input  bk_status_t         status,
    input  logic               q_full,
    output logic               q_push,
    output req_t               q_data,
    output logic [14:0]        mate_thr
);

    logic [14:0]        thr_reg;
    logic [14:0]        thr_next;
    logic signed [17:0] sc_ext;
    logic signed [17:0] thr_ext;
    logic signed [17:0] ply_ext;
    logic signed [17:0] adj;
    logic signed [15:0] adj_sat;
    op_t                op;

    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_wr_en)
        begin
            thr_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= MATE_THRESHOLD_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign mate_thr = thr_reg;

    always_comb
    begin
        case (func)
            FUNC_PROBE: op = OP_PROBE;
            FUNC_STORE: op = OP_STORE;
            FUNC_CLEAR: op = OP_CLEAR;
            default:    op = OP_NOP;
        endcase
    end

    // Shift mate scores away from the root, then saturate to 16 bits
    always_comb
    begin
        sc_ext  = {{2{score[15]}}, score};
        thr_ext = $signed({3'b000, thr_reg});
        ply_ext = $signed({10'd0, ply});
        if (sc_ext > thr_ext)
        begin
            adj = sc_ext + ply_ext;
        end
        else if (sc_ext < -thr_ext)
        begin
            adj = sc_ext - ply_ext;
        end
        else
        begin
            adj = sc_ext;
        end
        if (adj > 18'sd32767)
        begin
            adj_sat = 16'sh7FFF;
        end
        else if (adj < -18'sd32768)
        begin
            adj_sat = 16'sh8000;
        end
        else
        begin
            adj_sat = adj[15:0];
        end
    end

    // Hold requests off while the back end sweeps memory after reset or while the queue is full
    assign in_ready = !status.init_busy && !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        q_data.op    = op;
        q_data.key   = pos_key;
        q_data.depth = depth;
        q_data.alpha = alpha;
        q_data.beta  = beta;
        q_data.ply   = ply;
        q_data.bound = bound_kind;
        q_data.score = adj_sat;
        q_data.move  = move_in;
    end

endmodule

[sv/ttps_queue.sv]
// Two-entry request queue between front and back end.
// Depends on ttps_pkg for the request type.
module ttps_queue
    import ttps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t push_data,
    output logic full,
    input  logic pop,
    output req_t head,
    output logic empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    req_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/ttps_back.sv]
// Back end: entry memory, clearing sweep, probe/store execution and the
// result register. Depends on ttps_pkg.
module ttps_back
    import ttps_pkg::*;
#(
    parameter int INDEX_BITS = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  req_t               q_head,
    output logic               q_pop,
    input  logic [14:0]        mate_thr,
    output bk_status_t         status,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               key_hit,
    output logic [31:0]        move_out,
    output logic               cutoff,
    output logic signed [15:0] score_out,
    output logic               stored
);

    localparam int DEPTH = 1 << INDEX_BITS;

    entry_t                entry_mem [DEPTH];
    entry_t                rd_data_reg;
    req_t                  item_reg;
    bk_state_t             state_reg;
    bk_state_t             state_next;
    logic [INDEX_BITS-1:0] clr_addr_reg;
    logic [INDEX_BITS-1:0] clr_addr_next;
    logic                  clr_last;

    logic                  mem_wr_en;
    logic [INDEX_BITS-1:0] mem_wr_addr;
    entry_t                mem_wr_data;
    logic                  load_out;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  key_hit_reg;
    logic [31:0]           move_out_reg;
    logic                  cutoff_reg;
    logic signed [15:0]    score_out_reg;
    logic                  stored_reg;

    logic                  res_hit;
    logic [31:0]           res_move;
    logic                  res_cut;
    logic signed [15:0]    res_score;
    logic                  res_stored;
    logic                  replace;
    entry_t                new_entry;

    logic signed [17:0]    s_ext;
    logic signed [17:0]    s_adj;
    logic signed [17:0]    thr_ext;
    logic signed [17:0]    ply_ext;
    logic signed [17:0]    alpha_ext;
    logic signed [17:0]    beta_ext;

    assign clr_last = &clr_addr_reg;

    // Next state
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            BK_INIT:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                clr_addr_next = '0;
                if (!q_empty)
                begin
                    state_next = (q_head.op == OP_CLEAR) ? BK_CLEAR : BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                // Finish through EXEC to report the clear
                if (clr_last)
                begin
                    state_next = BK_EXEC;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Outputs of the state machine
    always_comb
    begin
        q_pop       = 1'b0;
        load_out    = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = clr_addr_reg;
        mem_wr_data = '0;
        status.init_busy = 1'b0;
        case (state_reg)
            BK_INIT:
            begin
                status.init_busy = 1'b1;
                mem_wr_en        = 1'b1;
            end
            BK_IDLE:
            begin
                q_pop = !q_empty;
            end
            BK_EXEC:
            begin
                load_out    = !out_valid_reg || out_ready;
                mem_wr_en   = load_out && res_stored;
                mem_wr_addr = item_reg.key[INDEX_BITS-1:0];
                mem_wr_data = new_entry;
            end
            BK_CLEAR:
            begin
                mem_wr_en = 1'b1;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Probe score: shift mate scores toward the root, then window test.
    // The two shifts apply in turn, the second one to the shifted score.
    always_comb
    begin
        thr_ext   = $signed({3'b000, mate_thr});
        ply_ext   = $signed({10'd0, item_reg.ply});
        s_ext     = {{2{rd_data_reg.score[15]}}, rd_data_reg.score};
        alpha_ext = {{2{item_reg.alpha[15]}}, item_reg.alpha};
        beta_ext  = {{2{item_reg.beta[15]}}, item_reg.beta};
        s_adj     = s_ext;
        if (s_ext > thr_ext)
        begin
            s_adj = s_ext - ply_ext;
        end
        if (s_adj < -thr_ext)
        begin
            s_adj = s_adj + ply_ext;
        end
    end

    always_comb
    begin
        replace = (rd_data_reg.key == 64'd0)
                  || (rd_data_reg.depth <= item_reg.depth)
                  || (rd_data_reg.key != item_reg.key);

        new_entry.key   = item_reg.key;
        new_entry.depth = item_reg.depth;
        new_entry.bound = item_reg.bound;
        new_entry.score = item_reg.score;
        // Keep the old move when the new one is empty
        new_entry.move  = (item_reg.move != 32'd0) ? item_reg.move : rd_data_reg.move;

        res_hit    = 1'b0;
        res_move   = 32'd0;
        res_cut    = 1'b0;
        res_score  = 16'sd0;
        res_stored = 1'b0;
        case (item_reg.op)
            OP_PROBE:
            begin
                if (rd_data_reg.key == item_reg.key)
                begin
                    res_hit  = 1'b1;
                    res_move = rd_data_reg.move;
                    if (rd_data_reg.depth >= item_reg.depth)
                    begin
                        case (rd_data_reg.bound)
                            BOUND_EXACT:
                            begin
                                res_cut   = 1'b1;
                                res_score = s_adj[15:0];
                            end
                            BOUND_UPPER:
                            begin
                                if (s_adj <= alpha_ext)
                                begin
                                    res_cut   = 1'b1;
                                    res_score = item_reg.alpha;
                                end
                            end
                            BOUND_LOWER:
                            begin
                                if (s_adj >= beta_ext)
                                begin
                                    res_cut   = 1'b1;
                                    res_score = item_reg.beta;
                                end
                            end
                            default:
                            begin
                                res_cut = 1'b0;
                            end
                        endcase
                    end
                end
            end
            OP_STORE:
            begin
                res_stored = replace;
            end
            default:
            begin
                res_stored = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_INIT;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_head;
        end
        if (load_out)
        begin
            key_hit_reg   <= res_hit;
            move_out_reg  <= res_move;
            cutoff_reg    <= res_cut;
            score_out_reg <= res_score;
            stored_reg    <= res_stored;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            entry_mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_data_reg <= entry_mem[q_head.key[INDEX_BITS-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign key_hit   = key_hit_reg;
    assign move_out  = move_out_reg;
    assign cutoff    = cutoff_reg;
    assign score_out = score_out_reg;
    assign stored    = stored_reg;

endmodule

[sv/transposition_table_probe_store.sv]
// Direct-mapped transposition table with 2**INDEX_BITS entries indexed by
// the low key bits. Requests enter a two-deep queue; the back end pops one
// in IDLE and reads its entry into a register, then in EXEC answers into
// the output register once that is free or being taken; a store that
// replaces also writes its entry back then. A clear sweeps one entry per
// cycle. After reset the same sweep runs with in_ready low; mate_threshold
// writes are taken throughout. Results wait in an output register, so the
// queue keeps filling while one is not taken. Depends on ttps_pkg,
// ttps_front, ttps_queue and ttps_back.
module transposition_table_probe_store
    import ttps_pkg::*;
#(
    parameter int INDEX_BITS = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [63:0]        pos_key,
    input  logic [7:0]         depth,
    input  logic signed [15:0] alpha,
    input  logic signed [15:0] beta,
    input  logic [7:0]         ply,
    input  logic [1:0]         bound_kind,
    input  logic signed [15:0] score,
    input  logic [31:0]        move_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               key_hit,
    output logic [31:0]        move_out,
    output logic               cutoff,
    output logic signed [15:0] score_out,
    output logic               stored,
    input  logic               cfg_wr_en,
    input  logic [14:0]        cfg_wr_data
);

    bk_status_t  status;
    logic        q_full;
    logic        q_push;
    req_t        q_data;
    logic        q_pop;
    req_t        q_head;
    logic        q_empty;
    logic [14:0] mate_thr;

    ttps_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .pos_key     (pos_key),
        .depth       (depth),
        .alpha       (alpha),
        .beta        (beta),
        .ply         (ply),
        .bound_kind  (bound_kind),
        .score       (score),
        .move_in     (move_in),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .status      (status),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_data),
        .mate_thr    (mate_thr)
    );

    ttps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    ttps_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .mate_thr  (mate_thr),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .key_hit   (key_hit),
        .move_out  (move_out),
        .cutoff    (cutoff),
        .score_out (score_out),
        .stored    (stored)
    );

endmodule

[tb/tb_transposition_table_probe_store.sv]
// Testbench for transposition_table_probe_store: directed and random probe, store
// and clear requests, checked against an in-bench predictor of the entry table.
// Depends on ttps_pkg and the transposition_table_probe_store RTL.
`timescale 1ns / 100ps

module tb_transposition_table_probe_store;
    import ttps_pkg::*;

    localparam int INDEX_BITS     = 12;
    localparam int KEY_HI_BITS    = 64 - INDEX_BITS;
    localparam int TT_ENTRIES     = 1 << INDEX_BITS;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 20000;

    // Codes the package leaves unnamed
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam logic [1:0] BOUND_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         func;
        logic [63:0]        key;
        logic [7:0]         depth;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic [7:0]         ply;
        logic [1:0]         bound;
        logic signed [15:0] score;
        logic [31:0]        move;
    } tt_request_t;

    typedef struct {
        logic               key_hit;
        logic [31:0]        move;
        logic               cutoff;
        logic signed [15:0] score;
        logic               stored;
    } tt_result_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [1:0]         func        = '0;
    logic [63:0]        pos_key     = '0;
    logic [7:0]         depth       = '0;
    logic signed [15:0] alpha       = '0;
    logic signed [15:0] beta        = '0;
    logic [7:0]         ply         = '0;
    logic [1:0]         bound_kind  = '0;
    logic signed [15:0] score       = '0;
    logic [31:0]        move_in     = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic               key_hit;
    logic [31:0]        move_out;
    logic               cutoff;
    logic signed [15:0] score_out;
    logic               stored;
    logic               cfg_wr_en   = 1'b0;
    logic [14:0]        cfg_wr_data = '0;

    // Predicted table contents and threshold
    logic [63:0]        table_key   [TT_ENTRIES];
    logic [7:0]         table_depth [TT_ENTRIES];
    logic [1:0]         table_bound [TT_ENTRIES];
    logic signed [15:0] table_score [TT_ENTRIES];
    logic [31:0]        table_move  [TT_ENTRIES];
    int                 mate_limit  = int'(MATE_THRESHOLD_RESET);

    tt_result_t  pending_results[$];
    logic [63:0] key_pool [16];
    logic [63:0] recent_key     = '0;
    int          mismatches     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_tickets   = 0;
    int          hold_served    = 0;
    int          hold_count     = 0;
    int          stall_cycles   = 0;

    transposition_table_probe_store #(
        .INDEX_BITS (INDEX_BITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .pos_key     (pos_key),
        .depth       (depth),
        .alpha       (alpha),
        .beta        (beta),
        .ply         (ply),
        .bound_kind  (bound_kind),
        .score       (score),
        .move_in     (move_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .key_hit     (key_hit),
        .move_out    (move_out),
        .cutoff      (cutoff),
        .score_out   (score_out),
        .stored      (stored),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void clear_table();
        for (int i = 0; i < TT_ENTRIES; i++)
        begin
            table_key[i]   = '0;
            table_depth[i] = '0;
            table_bound[i] = '0;
            table_score[i] = '0;
            table_move[i]  = '0;
        end
    endfunction

    function automatic tt_result_t predict_access(tt_request_t r);
        tt_result_t res;
        int         idx;
        int         s;
        int         ply_i;
        int         alpha_i;
        int         beta_i;
        logic       replace;
        res     = '{key_hit: 1'b0, move: '0, cutoff: 1'b0, score: '0, stored: 1'b0};
        idx     = int'(r.key[INDEX_BITS-1:0]);
        ply_i   = int'(r.ply);
        alpha_i = int'(r.alpha);
        beta_i  = int'(r.beta);
        case (r.func)
            FUNC_PROBE:
            begin
                if (table_key[idx] == r.key)
                begin
                    res.key_hit = 1'b1;
                    res.move    = table_move[idx];
                    if (table_depth[idx] >= r.depth)
                    begin
                        // shift mate scores toward the root; the two tests are sequential
                        s = int'(table_score[idx]);
                        if (s > mate_limit)
                            s = s - ply_i;
                        if (s < -mate_limit)
                            s = s + ply_i;
                        if (table_bound[idx] == BOUND_EXACT)
                        begin
                            res.cutoff = 1'b1;
                            res.score  = s[15:0];
                        end
                        else if (table_bound[idx] == BOUND_UPPER && s <= alpha_i)
                        begin
                            res.cutoff = 1'b1;
                            res.score  = r.alpha;
                        end
                        else if (table_bound[idx] == BOUND_LOWER && s >= beta_i)
                        begin
                            res.cutoff = 1'b1;
                            res.score  = r.beta;
                        end
                    end
                end
            end
            FUNC_STORE:
            begin
                replace = table_key[idx] == '0 || table_depth[idx] <= r.depth
                          || table_key[idx] != r.key;
                if (replace)
                begin
                    s = int'(r.score);
                    if (s > mate_limit)
                        s = s + ply_i;
                    if (s < -mate_limit)
                        s = s - ply_i;
                    if (s > 32767)
                        s = 32767;
                    if (s < -32768)
                        s = -32768;
                    table_key[idx]   = r.key;
                    table_depth[idx] = r.depth;
                    table_bound[idx] = r.bound;
                    table_score[idx] = s[15:0];
                    if (r.move != '0)
                        table_move[idx] = r.move;
                    res.stored = 1'b1;
                end
            end
            FUNC_CLEAR:
                clear_table();
            default:
                ;
        endcase
        return res;
    endfunction

    function automatic tt_request_t make_req(logic [1:0] f, logic [63:0] k, logic [7:0] d,
                                             logic signed [15:0] a, logic signed [15:0] b,
                                             logic [7:0] p, logic [1:0] bk,
                                             logic signed [15:0] sc, logic [31:0] mv);
        tt_request_t r;
        r.func  = f;
        r.key   = k;
        r.depth = d;
        r.alpha = a;
        r.beta  = b;
        r.ply   = p;
        r.bound = bk;
        r.score = sc;
        r.move  = mv;
        return r;
    endfunction

    // Mix of scores near the mate threshold, the range limits and anything else
    function automatic logic signed [15:0] pick_score();
        int v;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
        begin
            v = mate_limit + int'($urandom_range(0, 600)) - 300;
            if ($urandom_range(0, 1))
                v = -v;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
        end
        else if (sel < 35)
            v = $urandom_range(0, 1) ? 32767 : -32768;
        else
            v = $urandom;
        return v[15:0];
    endfunction

    function automatic tt_request_t rand_request();
        tt_request_t r;
        int          sel;
        sel = $urandom_range(0, 199);
        if (sel < 2)
            r.func = FUNC_CLEAR;
        else if (sel < 12)
            r.func = FUNC_UNUSED;
        else if (sel < 100)
            r.func = FUNC_STORE;
        else
            r.func = FUNC_PROBE;
        // bias probes toward the last stored key so lookups hit
        if (r.func == FUNC_PROBE && $urandom_range(0, 99) < 40)
            r.key = recent_key;
        else if ($urandom_range(0, 99) < 80)
            r.key = key_pool[4'($urandom_range(0, 15))];
        else
            r.key = {$urandom, $urandom};
        r.depth = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 15))
                                                : 8'($urandom_range(0, 255));
        r.alpha = pick_score();
        r.beta  = pick_score();
        r.score = pick_score();
        r.ply   = 8'($urandom_range(0, 255));
        r.bound = 2'($urandom_range(0, 3));
        r.move  = ($urandom_range(0, 99) < 20) ? 32'd0 : $urandom;
        if (r.func == FUNC_STORE)
            recent_key = r.key;
        return r;
    endfunction

    task automatic send_request(tt_request_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= r.func;
        pos_key    <= r.key;
        depth      <= r.depth;
        alpha      <= r.alpha;
        beta       <= r.beta;
        ply        <= r.ply;
        bound_kind <= r.bound;
        score      <= r.score;
        move_in    <= r.move;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_access(r));
    endtask

    // Drop valid and wait out every outstanding request
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_threshold(logic [14:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mate_limit  = int'(value);
    endtask

    task automatic test_cleared_table();
        send_request(make_req(FUNC_PROBE, 64'd0, 8'd0, 16'sd0, 16'sd0, 8'd0, BOUND_EXACT,
                              16'sd0, 32'd0));
        send_request(make_req(FUNC_PROBE, 64'd0, 8'd1, 16'sd0, 16'sd0, 8'd0, BOUND_EXACT,
                              16'sd0, 32'd0));
        send_request(make_req(FUNC_PROBE, 64'h0123_4567_89AB_C001, 8'd0, 16'sd0, 16'sd0,
                              8'd0, BOUND_EXACT, 16'sd0, 32'd0));
    endtask

    task automatic test_store_and_probe();
        logic [63:0] key_a;
        logic [63:0] key_b;
        logic [63:0] key_c;
        logic [63:0] key_d;
        logic [63:0] key_e;
        key_a = 64'h0123_4567_89AB_C001;
        key_b = 64'hFEDC_BA98_7654_3001;    // same entry as key_a
        key_c = 64'hFFFF_FFFF_FFFF_FFFF;
        key_d = 64'h8000_0000_0000_0002;
        key_e = 64'h5555_AAAA_5555_A003;
        send_request(make_req(FUNC_STORE, key_a, 8'd10, 16'sd0, 16'sd0, 8'd0, BOUND_EXACT,
                              16'sd100, 32'hDEAD_BEEF));
        send_request(make_req(FUNC_PROBE, key_a, 8'd10, 16'sd0, 16'sd0, 8'd0, BOUND_EXACT,
                              16'sd0, 32'd0));
        send_request(make_req(FUNC_PROBE, key_a, 8'd11, 16'sd0, 16'sd0, 8'd0, BOUND_EXACT,
                              16'sd0, 32'd0));
        // shallower store of the same key is refused
        send_request(make_req(FUNC_STORE, key_a, 8'd5, 16'sd0, 16'sd0, 8'd0, BOUND_EXACT,
                              16'sd1, 32'h1234_5678));
        // zero move keeps the stored move
        send_request(make_req(FUNC_STORE, key_a, 8'd10, 16'sd0, 16'sd0, 8'd0, BOUND_UPPER,
                              -16'sd50, 32'd0));
        send_request(make_req(FUNC_PROBE, key_a, 8'd0, -16'sd50, 16'sd0, 8'd0, BOUND_EXACT,
                              16'sd0, 32'd0));
        send_request(make_req(FUNC_PROBE, key_a, 8'd0, -16'sd51, 16'sd0, 8'd0, BOUND_EXACT,
                              16'sd0, 32'd0));
        send_request(make_req(FUNC_STORE, key_a, 8'd255, 16'sd0, 16'sd0, 8'd0, BOUND_LOWER,
                              16'sd200, 32'd1));
        send_request(make_req(FUNC_PROBE, key_a, 8'd255, -16'sd32768, 16'sd200, 8'd0,
                              BOUND_EXACT, 16'sd0, 32'd0));
        send_request(make_req(FUNC_PROBE, key_a, 8'd0, 16'sd32767, 16'sd201, 8'd0,
                              BOUND_EXACT, 16'sd0, 32'd0));
        // colliding key replaces; unused bound code never cuts off
        send_request(make_req(FUNC_STORE, key_b, 8'd0, 16'sd0, 16'sd0, 8'd0, BOUND_UNUSED,
                              16'sd7, 32'hFFFF_FFFF));
        send_request(make_req(FUNC_PROBE, key_b, 8'd0, 16'sd32767, -16'sd32768, 8'd0,
                              BOUND_EXACT, 16'sd0, 32'd0));
        // mate scores saturate on store and shift back on probe
        send_request(make_req(FUNC_STORE, key_c, 8'd3, 16'sd0, 16'sd0, 8'd255, BOUND_EXACT,
                              16'sd32767, 32'h0000_00A5));
        send_request(make_req(FUNC_PROBE, key_c, 8'd3, 16'sd0, 16'sd0, 8'd255, BOUND_EXACT,
                              16'sd0, 32'd0));
        send_request(make_req(FUNC_STORE, key_d, 8'd1, 16'sd0, 16'sd0, 8'd255, BOUND_EXACT,
                              -16'sd32768, 32'h8000_0000));
        send_request(make_req(FUNC_PROBE, key_d, 8'd0, 16'sd0, 16'sd0, 8'd10, BOUND_EXACT,
                              16'sd0, 32'd0));
        send_request(make_req(FUNC_STORE, key_e, 8'd2, 16'sd0, 16'sd0, 8'd100, BOUND_EXACT,
                              16'sd29001, 32'h0F0F_0F0F));
        send_request(make_req(FUNC_PROBE, key_e, 8'd2, 16'sd0, 16'sd0, 8'd1, BOUND_EXACT,
                              16'sd0, 32'd0));
        send_request(make_req(FUNC_UNUSED, key_e, 8'd255, 16'sd1, 16'sd1, 8'd1, BOUND_EXACT,
                              16'sd5, 32'h1111_1111));
        send_request(make_req(FUNC_PROBE, key_e, 8'd0, 16'sd0, 16'sd0, 8'd0, BOUND_EXACT,
                              16'sd0, 32'd0));
        send_request(make_req(FUNC_CLEAR, key_a, 8'd0, 16'sd0, 16'sd0, 8'd0, BOUND_EXACT,
                              16'sd0, 32'd0));
        send_request(make_req(FUNC_PROBE, key_b, 8'd0, 16'sd0, 16'sd0, 8'd0, BOUND_EXACT,
                              16'sd0, 32'd0));
    endtask

    task automatic test_random_traffic(int count, logic [14:0] threshold, int send_pct,
                                       int recv_pct);
        set_threshold(threshold);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) send_request(rand_request());
    endtask

    task automatic test_input_backpressure();
        set_threshold(MATE_THRESHOLD_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_tickets   = hold_tickets + 1;
        repeat (24) send_request(rand_request());
    endtask

    // Receiver: random stalls plus a long hold when requested
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_served != hold_tickets)
        begin
            hold_served <= hold_tickets;
            hold_count  <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else if (hold_count != 0)
        begin
            hold_count <= hold_count - 1;
            out_ready  <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        tt_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual hit=%0b move=%0h",
                         $time, key_hit, move_out);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("key_hit", 32'(want.key_hit), 32'(key_hit));
                check_field("move_out", want.move, move_out);
                check_field("cutoff", 32'(want.cutoff), 32'(cutoff));
                check_field("score_out", 32'(want.score), 32'(score_out));
                check_field("stored", 32'(want.stored), 32'(stored));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, no request moved for %0d cycles", $time, stall_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        clear_table();
        // pairs of keys that share an entry but differ above the index bits
        for (int i = 0; i < 16; i++)
        begin
            if (i % 2 == 0)
                key_pool[i] = {$urandom, $urandom};
            else
                key_pool[i] = {KEY_HI_BITS'({$urandom, $urandom}),
                               key_pool[i-1][INDEX_BITS-1:0]};
        end
        key_pool[0]  = '0;
        key_pool[15] = '1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_cleared_table();
        test_store_and_probe();
        test_random_traffic(95, 15'd0, 0, 0);
        test_random_traffic(95, 15'd32767, 55, 0);
        test_random_traffic(95, 15'($urandom_range(1, 32766)), 0, 55);
        test_random_traffic(95, 15'd1, 29, 29);
        test_input_backpressure();
        drain();

        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
